[hdl/ase_pkg.sv]
// shared constants and types for the array search engine
package ase_pkg;

   localparam int DEPTH   = 1024;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int RANGE_W = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int LEN_W   = 11;
   localparam int LIDX_W  = 10;
   localparam int POS_W   = 10;
   localparam int CMP_W   = 11;
   localparam int MODE_W  = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD = 2'd0,
      MODE_FWD  = 2'd1,
      MODE_BWD  = 2'd2,
      MODE_BIN  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

[hdl/ase_req_if.sv]
// request channel: load and query words
interface ase_req_if import ase_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic [LIDX_W-1:0]        load_index;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, mode, load_index, value, input ready);
   modport sink   (input valid, mode, load_index, value, output ready);
endinterface

[hdl/ase_rsp_if.sv]
// response channel: search results
interface ase_rsp_if import ase_pkg::*;;
   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] position;
   logic [CMP_W-1:0] comparisons;

   modport source (output valid, found, position, comparisons, input ready);
   modport sink   (input valid, found, position, comparisons, output ready);
endinterface

[hdl/ase_csr_if.sv]
// configuration write channel: array length
interface ase_csr_if import ase_pkg::*;;
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[hdl/ase_ram.sv]
// generic single-write single-read ram with registered read data
module ase_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hdl/array_search_engine_top.sv]
// array search engine: stored array with linear and binary search over a ram
// load word: accepted while idle, no response
// linear: one read per cycle, ending on the first hit or once every entry has been compared
// binary: each probe reads the midpoint, then compares the word and narrows the range before the next read
// one word in flight at a time; a finished response waits in an output register
// synchronous active-high reset clears control state and length; ram contents stay undefined
module array_search_engine_top import ase_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ase_req_if.sink   req_chan,
   ase_rsp_if.source rsp_chan,
   ase_csr_if.sink   csr_chan
);

   state_type                 state_ff, state_in;
   mode_type                  mode_ff, mode_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [RANGE_W-1:0]        lo_ff, lo_in;
   logic [RANGE_W-1:0]        hi_ff, hi_in;
   logic [RANGE_W-1:0]        cnt_ff, cnt_in;
   logic [ADDR_W-1:0]         cur_ff, cur_in;
   logic                      pend_ff, pend_in;
   logic                      found_ff, found_in;
   logic signed [DATA_W-1:0]  key_ff, key_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]          rsp_pos_ff, rsp_pos_in;
   logic [CMP_W-1:0]          rsp_cmp_ff, rsp_cmp_in;

   logic                      req_fire;
   mode_type                  req_mode;
   logic [RANGE_W-1:0]        active_len;
   logic                      ram_we;
   logic [ADDR_W-1:0]         ram_waddr;
   logic                      ram_re;
   logic [ADDR_W-1:0]         ram_raddr;
   logic [DATA_W-1:0]         ram_rdata;
   logic                      match;
   logic                      less;
   logic [RANGE_W-1:0]        lo_nx, hi_nx;
   logic [RANGE_W:0]          mid_sum;
   logic                      out_free;

   ase_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_chan.value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.position    = rsp_pos_ff;
   assign rsp_chan.comparisons = rsp_cmp_ff;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign req_mode   = mode_type'(req_chan.mode);
   assign active_len = (32'(len_ff) > 32'(DEPTH)) ? RANGE_W'(DEPTH) : RANGE_W'(len_ff);
   // loads happen only in idle and reads only in search, so no write/read overlap
   assign ram_we     = req_fire && (req_mode == MODE_LOAD) &&
                       (32'(req_chan.load_index) < 32'(DEPTH));
   assign ram_waddr  = ADDR_W'(req_chan.load_index);
   assign match      = pend_ff && ($signed(ram_rdata) == key_ff);
   assign less       = $signed(ram_rdata) < key_ff;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      len_in       = len_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      pend_in      = 1'b0;
      found_in     = found_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_cmp_in   = rsp_cmp_ff;
      ram_re       = 1'b0;
      ram_raddr    = '0;
      lo_nx        = lo_ff;
      hi_nx        = hi_ff;
      mid_sum      = '0;

      if (csr_chan.valid && csr_chan.ready) begin
         len_in = csr_chan.data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_mode != MODE_LOAD)) begin
               state_in = ST_SEARCH;
               mode_in  = req_mode;
               key_in   = req_chan.value;
               lo_in    = '0;
               hi_in    = active_len;
               cnt_in   = '0;
               found_in = 1'b0;
            end
         end
         ST_SEARCH: begin
            // binary probe narrows the range from the word read last cycle
            if (pend_ff && !match && (mode_ff == MODE_BIN)) begin
               if (less) begin
                  lo_nx = RANGE_W'(cur_ff) + 1'b1;
               end else begin
                  hi_nx = RANGE_W'(cur_ff);
               end
            end
            if (pend_ff) begin
               cnt_in = cnt_ff + 1'b1;
            end
            mid_sum = {1'b0, lo_nx} + {1'b0, hi_nx} - 1'b1;
            if (match) begin
               found_in = 1'b1;
               state_in = ST_FINISH;
            end else if (!pend_ff && (lo_ff >= hi_ff)) begin
               state_in = ST_FINISH;
            end else if ((lo_nx < hi_nx) && ((mode_ff != MODE_BIN) || !pend_ff)) begin
               ram_re  = 1'b1;
               pend_in = 1'b1;
               case (mode_ff)
                  MODE_FWD: begin
                     ram_raddr = lo_nx[ADDR_W-1:0];
                     lo_nx     = lo_nx + 1'b1;
                  end
                  MODE_BWD: begin
                     hi_nx     = hi_nx - 1'b1;
                     ram_raddr = hi_nx[ADDR_W-1:0];
                  end
                  default: begin
                     ram_raddr = mid_sum[ADDR_W:1];
                  end
               endcase
               cur_in = ram_raddr;
            end
            lo_in = lo_nx;
            hi_in = hi_nx;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_pos_in   = found_ff ? POS_W'(cur_ff) : '0;
               rsp_cmp_in   = CMP_W'(cnt_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      cnt_ff       <= cnt_in;
      cur_ff       <= cur_in;
      found_ff     <= found_in;
      key_ff       <= key_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_cmp_ff   <= rsp_cmp_in;
   end

endmodule

[hdl/ase_checker.sv]
// port-level checks for the array search engine, bound to the top level
module ase_checker import ase_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_found,
   input logic [POS_W-1:0] rsp_position,
   input logic [CMP_W-1:0] rsp_comparisons
);

   // a stalled response stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a miss always reports position zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss with nonzero position");

   // a hit needs at least one compare, and no search exceeds the array size
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_found || rsp_comparisons != '0) &&
                    (32'(rsp_comparisons) <= 32'(DEPTH)))
      else $error("comparison count out of range");

   // no response in the cycle after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind array_search_engine_top ase_checker u_ase_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_found       (rsp_chan.found),
   .rsp_position    (rsp_chan.position),
   .rsp_comparisons (rsp_chan.comparisons)
);

[test/array_search_engine_top_tb.sv]
// testbench for the array search engine: loads, linear and binary queries, length register
module array_search_engine_top_tb import ase_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
      logic [CMP_W-1:0] comparisons;
   } search_answer;

   // mirror of the stored array and length; predicts each query answer in order
   class search_tracker;
      logic signed [DATA_W-1:0] store [DEPTH];
      int                       length;
      search_answer             answers_due [$];
      int                       errors;

      function void set_length(logic [LEN_W-1:0] data);
         length = (data > DEPTH) ? DEPTH : int'(data);
      endfunction

      function void note_word(mode_type mode, logic [LIDX_W-1:0] index,
                              logic signed [DATA_W-1:0] value);
         search_answer ans;
         int           lo;
         int           hi;
         int           mid;
         int           i;
         ans = '0;
         if (mode == MODE_LOAD) begin
            store[index] = value;
            return;
         end
         case (mode)
            MODE_FWD: begin
               for (i = 0; i < length && !ans.found; i++) begin
                  ans.comparisons++;
                  if (store[i] == value) begin
                     ans.found    = 1'b1;
                     ans.position = POS_W'(i);
                  end
               end
            end
            MODE_BWD: begin
               for (i = length - 1; i >= 0 && !ans.found; i--) begin
                  ans.comparisons++;
                  if (store[i] == value) begin
                     ans.found    = 1'b1;
                     ans.position = POS_W'(i);
                  end
               end
            end
            default: begin
               lo = 0;
               hi = length;
               while (lo < hi && !ans.found) begin
                  mid = (lo + hi - 1) / 2;
                  ans.comparisons++;
                  if (store[mid] == value) begin
                     ans.found    = 1'b1;
                     ans.position = POS_W'(mid);
                  end else if (store[mid] < value) begin
                     lo = mid + 1;
                  end else begin
                     hi = mid;
                  end
               end
            end
         endcase
         answers_due.push_back(ans);
      endfunction

      function void check_result(logic found, logic [POS_W-1:0] position,
                                 logic [CMP_W-1:0] comparisons);
         search_answer want;
         if (answers_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: found %b position %0d comparisons %0d",
                     $time, found, position, comparisons);
            return;
         end
         want = answers_due.pop_front();
         if (found !== want.found) begin
            errors++;
            $display("%0t: found expected %b actual %b", $time, want.found, found);
         end
         if (position !== want.position) begin
            errors++;
            $display("%0t: position expected %0d actual %0d", $time, want.position, position);
         end
         if (comparisons !== want.comparisons) begin
            errors++;
            $display("%0t: comparisons expected %0d actual %0d",
                     $time, want.comparisons, comparisons);
         end
      endfunction

      function void close_out();
         if (answers_due.size() != 0) begin
            errors++;
            $display("%0t: %0d results missing, next expected found %b position %0d comparisons %0d",
                     $time, answers_due.size(), answers_due[0].found,
                     answers_due[0].position, answers_due[0].comparisons);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   words_accepted;

   search_tracker tracker = new;

   ase_req_if req_chan ();
   ase_rsp_if rsp_chan ();
   ase_csr_if csr_chan ();

   array_search_engine_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("array_search_engine_top_tb: errors");
      $finish;
   end

   // result side: random stall before each word
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         tracker.check_result(rsp_chan.found, rsp_chan.position, rsp_chan.comparisons);
   end

   // valid stays high after acceptance until the next call decides
   task automatic send_word(mode_type mode, logic [LIDX_W-1:0] index,
                            logic signed [DATA_W-1:0] value);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.load_index <= index;
      req_chan.value      <= value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      words_accepted++;
      tracker.note_word(mode, index, value);
   endtask

   // wait for all answers, plus slack for a load still in flight
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (tracker.answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_length(logic [LEN_W-1:0] data);
      settle();
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= data;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      csr_chan.valid <= 1'b0;
      tracker.set_length(data);
   endtask

   // an entry on the leftmost or rightmost binary probe path of the full array
   function automatic int path_index();
      int step;
      step = 1 << $urandom_range(0, 9);
      return $urandom_range(0, 1) ? step - 1 : DEPTH - 1 - step;
   endfunction

   task automatic run_directed();
      // zero length after reset
      send_word(MODE_FWD, '0, 0);
      send_word(MODE_BWD, '1, 0);
      send_word(MODE_BIN, '0, 32'sh7fff_ffff);
      // sorted, with duplicates and both extremes
      send_word(MODE_LOAD, 10'd0, 32'sh8000_0000);
      send_word(MODE_LOAD, 10'd1, -32'sd5);
      send_word(MODE_LOAD, 10'd2, 32'sd0);
      send_word(MODE_LOAD, 10'd3, 32'sd0);
      send_word(MODE_LOAD, 10'd4, 32'sd0);
      send_word(MODE_LOAD, 10'd5, 32'sd7);
      send_word(MODE_LOAD, 10'd6, 32'sd100);
      send_word(MODE_LOAD, 10'd7, 32'sh7fff_ffff);
      send_word(MODE_LOAD, 10'd1023, 32'sh1234_5678);
      write_length(LEN_W'(8));
      send_word(MODE_FWD, '0, 32'sd0);
      send_word(MODE_BWD, '0, 32'sd0);
      send_word(MODE_BIN, '0, 32'sd0);
      send_word(MODE_BIN, '0, 32'sh8000_0000);
      send_word(MODE_BIN, '0, 32'sh7fff_ffff);
      send_word(MODE_FWD, '0, 32'sh7fff_ffff);
      send_word(MODE_BWD, '0, 32'sh8000_0000);
      send_word(MODE_BIN, '0, 32'sd1);
      send_word(MODE_FWD, '1, 32'sd1);
      // break the ordering under binary search
      send_word(MODE_LOAD, 10'd3, 32'sd200);
      send_word(MODE_BIN, '0, 32'sd200);
      send_word(MODE_BIN, '0, 32'sd7);
   endtask

   task automatic run_phase();
      logic signed [DATA_W-1:0] fill [DEPTH];
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] held;
      int unsigned              len;
      int unsigned              queries;
      int unsigned              pick;
      int unsigned              k;
      int unsigned              j;
      bit                       ordered;
      bit                       wide;
      bit                       reverse;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         len = 0;
      else if (pick < 7)
         len = $urandom_range(1, 16);
      else if (pick < 9)
         len = $urandom_range(17, 64);
      else
         len = $urandom_range(65, 200);
      calm    = ($urandom_range(0, 4) == 0);
      ordered = ($urandom_range(0, 3) != 0);
      wide    = $urandom_range(0, 1);
      reverse = $urandom_range(0, 1);
      for (k = 0; k < len; k++)
         fill[k] = wide ? $urandom : $urandom_range(0, 40) - 32'd20;
      if (ordered) begin
         for (k = 1; k < len; k++) begin
            held = fill[k];
            j    = k;
            while (j > 0 && fill[j-1] > held) begin
               fill[j] = fill[j-1];
               j--;
            end
            fill[j] = held;
         end
      end
      for (k = 0; k < len; k++) begin
         j = reverse ? len - 1 - k : k;
         send_word(MODE_LOAD, LIDX_W'(j), fill[j]);
      end
      write_length(LEN_W'(len));
      queries = $urandom_range(8, 30);
      for (k = 0; k < queries; k++) begin
         if ($urandom_range(0, 24) == 0)
            settle();
         if ($urandom_range(0, 7) == 0) begin
            j = (len > 0 && $urandom_range(0, 1)) ? $urandom_range(0, len - 1)
                                                  : $urandom_range(0, DEPTH - 1);
            send_word(MODE_LOAD, LIDX_W'(j), $urandom);
         end
         pick = $urandom_range(0, 9);
         if (len == 0 || pick == 8) begin
            key = $urandom;
         end else if (pick == 9) begin
            key = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end else begin
            key = tracker.store[$urandom_range(0, len - 1)];
            if (pick == 6) key = key + 1;
            if (pick == 7) key = key - 1;
         end
         pick = $urandom_range(0, ordered ? 4 : 2);
         send_word(pick == 0 ? MODE_FWD : (pick == 1 ? MODE_BWD : MODE_BIN),
                   LIDX_W'($urandom_range(0, DEPTH - 1)), key);
      end
   endtask

   // ascending entries on the outer binary probe paths, then full and saturated lengths
   task automatic run_full_depth();
      logic signed [DATA_W-1:0] word;
      int                       k;
      calm = $urandom_range(0, 1);
      for (k = 0; k < DEPTH; k++) begin
         // every query below reads only these entries
         if ((((k + 1) & k) == 0) || (((DEPTH - 1 - k) & (DEPTH - 2 - k)) == 0)) begin
            if (k == 0)
               word = 32'sh8000_0000;
            else if (k == DEPTH - 1)
               word = 32'sh7fff_ffff;
            else
               word = 32'h8000_0000 + k * 32'h40_0000 + $urandom_range(0, 32'h3f_ffff);
            send_word(MODE_LOAD, LIDX_W'(k), word);
         end
      end
      calm = 1'b0;
      write_length(LEN_W'(DEPTH));
      send_word(MODE_FWD, '0, tracker.store[0]);
      send_word(MODE_BWD, '0, tracker.store[DEPTH-1]);
      for (k = 0; k < 6; k++)
         send_word(MODE_BIN, '0, tracker.store[path_index()]);
      send_word(MODE_BIN, '0, tracker.store[0] + 1);
      send_word(MODE_BIN, '0, tracker.store[DEPTH-1] - 1);
      send_word(MODE_BIN, '0, 32'sh8000_0000);
      send_word(MODE_BIN, '0, 32'sh7fff_ffff);
      write_length('1);
      send_word(MODE_FWD, '0, tracker.store[0]);
      send_word(MODE_BIN, '0, tracker.store[path_index()]);
      send_word(MODE_BWD, '0, tracker.store[DEPTH-1]);
      write_length(LEN_W'(DEPTH + 1));
      send_word(MODE_BIN, '0, tracker.store[DEPTH-1]);
      send_word(MODE_FWD, '0, tracker.store[0]);
   endtask

   initial begin
      int spin;
      int base;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.mode       <= MODE_LOAD;
      req_chan.load_index <= '0;
      req_chan.value      <= '0;
      csr_chan.valid      <= 1'b0;
      csr_chan.data       <= '0;
      calm                = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      base = words_accepted;
      while (words_accepted - base < 500)
         run_phase();
      run_full_depth();

      req_chan.valid <= 1'b0;
      for (spin = 0; spin < 200000 && tracker.answers_due.size() != 0; spin++)
         @(posedge clock);
      repeat (1100) @(posedge clock);
      tracker.close_out();
      if (tracker.errors == 0)
         $display("array_search_engine_top_tb: clean");
      else
         $display("array_search_engine_top_tb: errors");
      $finish;
   end

endmodule

[array_search_engine_top.f]
hdl/ase_pkg.sv
hdl/ase_req_if.sv
hdl/ase_rsp_if.sv
hdl/ase_csr_if.sv
hdl/ase_ram.sv
hdl/array_search_engine_top.sv
hdl/ase_checker.sv
test/array_search_engine_top_tb.sv
